// ===== design/opgc_pkg.sv =====
package opgc_pkg;

  // CORDIC settings: iteration count, start value and result width.
  localparam int unsigned CORDIC_STEPS = 15;
  localparam int unsigned TRIG_W       = 18;
  localparam logic [TRIG_W-1:0] CORDIC_START = 18'd39797;

  // Serial multiplier operand and accumulator widths.
  localparam int unsigned OPA_W = 34;
  localparam int unsigned OPB_W = 18;
  localparam int unsigned ACC_W = 54;

  // Serial divider dividend width.
  localparam int unsigned DIV_W = 24;

  // Radians to binary angle scale, Q16.
  localparam logic [29:0] RAD_TO_BAM_Q16 = 30'd683565276;

  // Unit target distance in Q16.16.
  localparam logic signed [OPA_W-1:0] UNIT_Q16 = 34'sd65536;

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_JOY  = 1'b1;

  // Target select codes.
  localparam logic [2:0] SEL_KEEP = 3'd0;
  localparam logic [2:0] SEL_PX   = 3'd1;
  localparam logic [2:0] SEL_NY   = 3'd4;

  // Configuration register indexes.
  localparam logic REG_LINEAR_GAIN  = 1'b0;
  localparam logic REG_ANGULAR_GAIN = 1'b1;

  typedef enum logic [1:0] {
    DIR_PX = 2'd0,
    DIR_PY = 2'd1,
    DIR_NX = 2'd2,
    DIR_NY = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    STEP_DX = 3'd0,
    STEP_DY = 3'd1,
    STEP_HD = 3'd2,
    STEP_MX = 3'd3,
    STEP_MY = 3'd4,
    STEP_JF = 3'd5,
    STEP_JS = 3'd6,
    STEP_JT = 3'd7
  } step_e;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clr;
    logic neg;
  } mac_ctl_t;

  // Arctangent of 2^-i as binary angle.
  function automatic logic [13:0] atan_bam(input logic [3:0] idx);
    logic [13:0] r;
    case (idx)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/opgc_cordic.sv =====
module opgc_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [15:0]                          angle_i,
  output logic                                 busy_o,
  output logic signed [opgc_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [opgc_pkg::TRIG_W-1:0]   sin_o
);

  localparam int unsigned XY_W = opgc_pkg::TRIG_W + 1;
  localparam int unsigned Z_W  = 18;

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d, sx, sy;
  logic signed [Z_W-1:0]  z_q, z_d, at;
  logic [3:0]             cnt_q, cnt_d;
  logic                   busy_q, busy_d, flip_q, flip_d;
  logic [15:0]            rot, fold;

  // Fold the angle into the right half plane.
  assign rot  = angle_i + 16'h4000;
  assign fold = rot[15] ? (angle_i ^ 16'h8000) : angle_i;

  assign sx = y_q >>> cnt_q;
  assign sy = x_q >>> cnt_q;
  assign at = $signed({{(Z_W-14){1'b0}}, opgc_pkg::atan_bam(cnt_q)});

  // One rotation step per cycle.
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    flip_d = flip_q;
    if (start_i) begin
      x_d    = $signed({1'b0, opgc_pkg::CORDIC_START});
      y_d    = '0;
      z_d    = $signed({{(Z_W-16){fold[15]}}, fold});
      cnt_d  = '0;
      busy_d = 1'b1;
      flip_d = rot[15];
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - sx;
        y_d = y_q + sy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + sx;
        y_d = y_q - sy;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(opgc_pkg::CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  // Undo the fold by negating both results.
  assign cos_o  = flip_q ? opgc_pkg::TRIG_W'(-x_q) : x_q[opgc_pkg::TRIG_W-1:0];
  assign sin_o  = flip_q ? opgc_pkg::TRIG_W'(-y_q) : y_q[opgc_pkg::TRIG_W-1:0];
  assign busy_o = busy_q;

endmodule

// ===== design/opgc_mac.sv =====
module opgc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  opgc_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [opgc_pkg::OPA_W-1:0]  a_i,
  input  logic signed [opgc_pkg::OPB_W-1:0]  b_i,
  output logic                               busy_o,
  output logic signed [opgc_pkg::ACC_W-1:0]  acc_o
);

  localparam int unsigned CNT_W = $clog2(opgc_pkg::OPB_W);

  logic signed [opgc_pkg::ACC_W-1:0] acc_q, acc_d, a_q, a_d;
  logic [opgc_pkg::OPB_W-1:0]        b_q, b_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic                              busy_q, busy_d, neg_q, neg_d, last;

  assign last = (cnt_q == CNT_W'(opgc_pkg::OPB_W - 1));

  // Shift-add over the multiplier one bit per cycle; its sign bit has negative weight.
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    if (ctl_i.start) begin
      if (ctl_i.clr) begin
        acc_d = '0;
      end
      a_d    = {{(opgc_pkg::ACC_W-opgc_pkg::OPA_W){a_i[opgc_pkg::OPA_W-1]}}, a_i};
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      neg_d  = ctl_i.neg;
    end else if (busy_q) begin
      if (b_q[0]) begin
        if (last ^ neg_q) begin
          acc_d = acc_q - a_q;
        end else begin
          acc_d = acc_q + a_q;
        end
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

// ===== design/opgc_div.sv =====
module opgc_div #(
  parameter int unsigned DIVISOR = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [opgc_pkg::DIV_W-1:0] num_i,
  output logic                       busy_o,
  output logic [opgc_pkg::DIV_W-1:0] quot_o
);

  localparam int unsigned RW    = $clog2(DIVISOR + 1);
  localparam int unsigned CNT_W = $clog2(opgc_pkg::DIV_W);

  logic [RW-1:0]                rem_q, rem_d;
  logic [RW:0]                  trial;
  logic [opgc_pkg::DIV_W-1:0]   num_q, num_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         busy_q, busy_d, fits;

  assign trial = {rem_q, num_q[opgc_pkg::DIV_W-1]};
  assign fits  = (trial >= (RW+1)'(DIVISOR));

  // Restoring division, one quotient bit per cycle shifted in at the bottom.
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? RW'(trial - (RW+1)'(DIVISOR)) : trial[RW-1:0];
      num_d = {num_q[opgc_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(opgc_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;

endmodule

// ===== design/odometry_pose_goto_controller.sv =====
// Channel  Handshake                      Payload
// input    in_valid_i / in_stall_o        command_i, odo_*_i, target_select_i, hold_button_i, axis_*_i
// output   out_valid_o / out_stall_i      pos_x_o, pos_y_o, heading_o, cmd_x_o, cmd_y_o, cmd_turn_o
// config   cfg_we_i                       cfg_index_i, cfg_wdata_i
//
// A tick beat makes two 15-step CORDIC runs, nine passes of the bit-serial
// multiplier and three passes of the serial divider.
// A joystick beat makes three multiplier passes; a hold beat uses no arithmetic unit.
// One beat is processed at a time; the next is accepted while a result waits.
// Reset is asynchronous and active low and restores pose, target, move and gains.
// A stalled result stays in the output register; work then pauses at its end.
module odometry_pose_goto_controller #(
  parameter int unsigned TICK_RATE_HZ = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [15:0] odo_vel_x_i,
  input  logic signed [15:0] odo_vel_y_i,
  input  logic signed [15:0] odo_yaw_rate_i,
  input  logic [2:0]         target_select_i,
  input  logic               hold_button_i,
  input  logic signed [15:0] axis_forward_i,
  input  logic signed [15:0] axis_side_i,
  input  logic signed [15:0] axis_turn_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_o,
  output logic signed [15:0] cmd_x_o,
  output logic signed [15:0] cmd_y_o,
  output logic signed [15:0] cmd_turn_o
);

  localparam int unsigned OPA_W = opgc_pkg::OPA_W;
  localparam int unsigned OPB_W = opgc_pkg::OPB_W;
  localparam int unsigned ACC_W = opgc_pkg::ACC_W;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_CORS  = 12'b000000000010,
    ST_CORW  = 12'b000000000100,
    ST_M1S   = 12'b000000001000,
    ST_M1W   = 12'b000000010000,
    ST_M2S   = 12'b000000100000,
    ST_M2W   = 12'b000001000000,
    ST_POST  = 12'b000010000000,
    ST_DIVS  = 12'b000100000000,
    ST_DIVW  = 12'b001000000000,
    ST_APPLY = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_e              state_q, state_d;
  opgc_pkg::step_e     step_q, step_d;
  opgc_pkg::dir_e      dir_q, dir_d;
  logic [15:0]         lin_gain_q, lin_gain_d, ang_gain_q, ang_gain_d;
  logic signed [31:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [15:0]         head_q, head_d;
  logic signed [15:0]  move_x_q, move_x_d, move_y_q, move_y_d;
  logic signed [15:0]  cmd_x_q, cmd_x_d, cmd_y_q, cmd_y_d, cmd_t_q, cmd_t_d;
  logic signed [15:0]  vx_q, vx_d, vy_q, vy_d, wr_q, wr_d;
  logic signed [15:0]  axf_q, axf_d, axs_q, axs_d, axt_q, axt_d;
  logic [31:0]         mag_q, mag_d;
  logic                sign_q, sign_d;
  logic                out_valid_q, out_valid_d;
  logic signed [31:0]  out_px_q, out_px_d, out_py_q, out_py_d;
  logic [15:0]         out_hd_q, out_hd_d;
  logic signed [15:0]  out_cx_q, out_cx_d, out_cy_q, out_cy_d, out_ct_q, out_ct_d;

  logic                accept, out_load, two_op, use_div;
  logic                cor_busy, mac_busy, div_busy;
  logic signed [opgc_pkg::TRIG_W-1:0] cos_w, sin_w;
  logic signed [OPA_W-1:0] mac_a, tx, ty, dif_x, dif_y;
  logic signed [OPB_W-1:0] mac_b;
  logic signed [ACC_W-1:0] acc;
  opgc_pkg::mac_ctl_t      mac_ctl;
  logic [ACC_W-1:0]        mag_abs, shifted;
  logic [5:0]              sh_amt;
  logic [opgc_pkg::DIV_W-1:0] quot;
  logic signed [33:0]      res, pos_sum_x, pos_sum_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Error from the position to the selected unit target.
  always_comb begin
    tx = '0;
    ty = '0;
    case (dir_q)
      opgc_pkg::DIR_PX: tx = opgc_pkg::UNIT_Q16;
      opgc_pkg::DIR_PY: ty = opgc_pkg::UNIT_Q16;
      opgc_pkg::DIR_NX: tx = -opgc_pkg::UNIT_Q16;
      opgc_pkg::DIR_NY: ty = -opgc_pkg::UNIT_Q16;
      default: begin
        tx = '0;
        ty = '0;
      end
    endcase
  end
  assign dif_x = tx - {{(OPA_W-32){pos_x_q[31]}}, pos_x_q};
  assign dif_y = ty - {{(OPA_W-32){pos_y_q[31]}}, pos_y_q};

  // Multiplier operands for each step and pass.
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_ctl.start = (state_q == ST_M1S) || (state_q == ST_M2S);
    mac_ctl.clr   = (state_q == ST_M1S);
    mac_ctl.neg   = 1'b0;
    two_op  = 1'b0;
    use_div = 1'b0;
    sh_amt  = 6'd14;
    case (step_q)
      opgc_pkg::STEP_DX: begin
        two_op  = 1'b1;
        use_div = 1'b1;
        sh_amt  = 6'd12;
        if (state_q == ST_M2S) begin
          mac_a       = {{(OPA_W-16){vy_q[15]}}, vy_q};
          mac_b       = sin_w;
          mac_ctl.neg = 1'b1;
        end else begin
          mac_a = {{(OPA_W-16){vx_q[15]}}, vx_q};
          mac_b = cos_w;
        end
      end
      opgc_pkg::STEP_DY: begin
        two_op  = 1'b1;
        use_div = 1'b1;
        sh_amt  = 6'd12;
        if (state_q == ST_M2S) begin
          mac_a = {{(OPA_W-16){vy_q[15]}}, vy_q};
          mac_b = cos_w;
        end else begin
          mac_a = {{(OPA_W-16){vx_q[15]}}, vx_q};
          mac_b = sin_w;
        end
      end
      opgc_pkg::STEP_HD: begin
        use_div = 1'b1;
        sh_amt  = 6'd28;
        mac_a   = {{(OPA_W-30){1'b0}}, opgc_pkg::RAD_TO_BAM_Q16};
        mac_b   = {{(OPB_W-16){wr_q[15]}}, wr_q};
      end
      opgc_pkg::STEP_MX: begin
        two_op = 1'b1;
        sh_amt = 6'd21;
        if (state_q == ST_M2S) begin
          mac_a = dif_y;
          mac_b = sin_w;
        end else begin
          mac_a = dif_x;
          mac_b = cos_w;
        end
      end
      opgc_pkg::STEP_MY: begin
        two_op = 1'b1;
        sh_amt = 6'd21;
        if (state_q == ST_M2S) begin
          mac_a       = dif_x;
          mac_b       = sin_w;
          mac_ctl.neg = 1'b1;
        end else begin
          mac_a = dif_y;
          mac_b = cos_w;
        end
      end
      opgc_pkg::STEP_JF: begin
        mac_a = {{(OPA_W-16){1'b0}}, lin_gain_q};
        mac_b = {{(OPB_W-16){axf_q[15]}}, axf_q};
      end
      opgc_pkg::STEP_JS: begin
        mac_a = {{(OPA_W-16){1'b0}}, lin_gain_q};
        mac_b = {{(OPB_W-16){axs_q[15]}}, axs_q};
      end
      opgc_pkg::STEP_JT: begin
        mac_a = {{(OPA_W-16){1'b0}}, ang_gain_q};
        mac_b = {{(OPB_W-16){axt_q[15]}}, axt_q};
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  // Truncation toward zero works on the magnitude.
  assign mag_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
  assign shifted   = mag_abs >> sh_amt;
  assign res       = sign_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
  assign pos_sum_x = {{2{pos_x_q[31]}}, pos_x_q} + res;
  assign pos_sum_y = {{2{pos_y_q[31]}}, pos_y_q} + res;

  // Sequencer and state update.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    dir_d      = dir_q;
    lin_gain_d = lin_gain_q;
    ang_gain_d = ang_gain_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    head_d     = head_q;
    move_x_d   = move_x_q;
    move_y_d   = move_y_q;
    cmd_x_d    = cmd_x_q;
    cmd_y_d    = cmd_y_q;
    cmd_t_d    = cmd_t_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    wr_d       = wr_q;
    axf_d      = axf_q;
    axs_d      = axs_q;
    axt_d      = axt_q;
    mag_d      = mag_q;
    sign_d     = sign_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        opgc_pkg::REG_LINEAR_GAIN:  lin_gain_d = cfg_wdata_i;
        opgc_pkg::REG_ANGULAR_GAIN: ang_gain_d = cfg_wdata_i;
        default: lin_gain_d = lin_gain_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          vx_d  = odo_vel_x_i;
          vy_d  = odo_vel_y_i;
          wr_d  = odo_yaw_rate_i;
          axf_d = axis_forward_i;
          axs_d = axis_side_i;
          axt_d = axis_turn_i;
          cmd_t_d = '0;
          if (command_i == opgc_pkg::CMD_TICK) begin
            step_d  = opgc_pkg::STEP_DX;
            state_d = ST_CORS;
          end else begin
            if (target_select_i inside {[opgc_pkg::SEL_PX:opgc_pkg::SEL_NY]}) begin
              dir_d = opgc_pkg::dir_e'(2'(target_select_i - opgc_pkg::SEL_PX));
            end
            if (hold_button_i) begin
              cmd_x_d = move_x_q;
              cmd_y_d = move_y_q;
              state_d = ST_DONE;
            end else begin
              step_d  = opgc_pkg::STEP_JF;
              state_d = ST_M1S;
            end
          end
        end
      end
      ST_CORS: state_d = ST_CORW;
      ST_CORW: begin
        if (!cor_busy) begin
          state_d = ST_M1S;
        end
      end
      ST_M1S: state_d = ST_M1W;
      ST_M1W: begin
        if (!mac_busy) begin
          state_d = two_op ? ST_M2S : ST_POST;
        end
      end
      ST_M2S: state_d = ST_M2W;
      ST_M2W: begin
        if (!mac_busy) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        sign_d  = acc[ACC_W-1];
        mag_d   = shifted[31:0];
        state_d = use_div ? ST_DIVS : ST_APPLY;
      end
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (!div_busy) begin
          mag_d   = {{(32-opgc_pkg::DIV_W){1'b0}}, quot};
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_M1S;
        case (step_q)
          opgc_pkg::STEP_DX: begin
            pos_x_d = sat32(pos_sum_x);
            step_d  = opgc_pkg::STEP_DY;
          end
          opgc_pkg::STEP_DY: begin
            pos_y_d = sat32(pos_sum_y);
            step_d  = opgc_pkg::STEP_HD;
          end
          opgc_pkg::STEP_HD: begin
            head_d  = head_q + res[15:0];
            step_d  = opgc_pkg::STEP_MX;
            state_d = ST_CORS;
          end
          opgc_pkg::STEP_MX: begin
            move_x_d = sat16(res);
            cmd_x_d  = sat16(res);
            step_d   = opgc_pkg::STEP_MY;
          end
          opgc_pkg::STEP_MY: begin
            move_y_d = sat16(res);
            cmd_y_d  = sat16(res);
            state_d  = ST_DONE;
          end
          opgc_pkg::STEP_JF: begin
            cmd_x_d = sat16(res);
            step_d  = opgc_pkg::STEP_JS;
          end
          opgc_pkg::STEP_JS: begin
            cmd_y_d = sat16(res);
            step_d  = opgc_pkg::STEP_JT;
          end
          opgc_pkg::STEP_JT: begin
            cmd_t_d = sat16(res);
            state_d = ST_DONE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = (out_valid_q && out_stall_i) || out_load;
    out_px_d    = out_px_q;
    out_py_d    = out_py_q;
    out_hd_d    = out_hd_q;
    out_cx_d    = out_cx_q;
    out_cy_d    = out_cy_q;
    out_ct_d    = out_ct_q;
    if (out_load) begin
      out_px_d = pos_x_q;
      out_py_d = pos_y_q;
      out_hd_d = head_q;
      out_cx_d = cmd_x_q;
      out_cy_d = cmd_y_q;
      out_ct_d = cmd_t_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= opgc_pkg::STEP_DX;
      dir_q       <= opgc_pkg::DIR_PX;
      lin_gain_q  <= 16'd4096;
      ang_gain_q  <= 16'd4096;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      move_x_q    <= '0;
      move_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dir_q       <= dir_d;
      lin_gain_q  <= lin_gain_d;
      ang_gain_q  <= ang_gain_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      head_q      <= head_d;
      move_x_q    <= move_x_d;
      move_y_q    <= move_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_x_q  <= cmd_x_d;
    cmd_y_q  <= cmd_y_d;
    cmd_t_q  <= cmd_t_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    wr_q     <= wr_d;
    axf_q    <= axf_d;
    axs_q    <= axs_d;
    axt_q    <= axt_d;
    mag_q    <= mag_d;
    sign_q   <= sign_d;
    out_px_q <= out_px_d;
    out_py_q <= out_py_d;
    out_hd_q <= out_hd_d;
    out_cx_q <= out_cx_d;
    out_cy_q <= out_cy_d;
    out_ct_q <= out_ct_d;
  end

  opgc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_CORS),
    .angle_i (head_q),
    .busy_o  (cor_busy),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  opgc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  opgc_div #(
    .DIVISOR (TICK_RATE_HZ)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIVS),
    .num_i   (mag_q[opgc_pkg::DIV_W-1:0]),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign heading_o   = out_hd_q;
  assign cmd_x_o     = out_cx_q;
  assign cmd_y_o     = out_cy_q;
  assign cmd_turn_o  = out_ct_q;

`ifndef SYNTHESIS
  // The heading only moves when the heading step is applied.
  a_head_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |-> ($past(state_q) == ST_APPLY &&
                                   $past(step_q) == opgc_pkg::STEP_HD))
    else $error("heading changed outside its update step");

  // The multiplier never runs at the same time as the other shared arithmetic units.
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cor_busy && mac_busy) && !(mac_busy && div_busy))
    else $error("arithmetic units overlap");

  // A multiplier pass is only started when the unit is free.
  a_mac_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M1S || state_q == ST_M2S) |-> !mac_busy)
    else $error("multiplier started while busy");
`endif

endmodule
